// File: sv/quad_area_centroid_defines.svh
// Assertion macros shared by the quadrilateral area and centroid block.
`ifndef QUAD_AREA_CENTROID_DEFINES_SVH
`define QUAD_AREA_CENTROID_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define QAC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must be followed in the next cycle by another.
`define QAC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define QAC_ASSERT(label, clk, rst, prop, msg)
`define QAC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: sv/qac_pkg.sv
// Package with widths and word types of the quadrilateral area and centroid block.
`timescale 1ns / 1ps
`default_nettype none
package qac_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int NUM_CORNERS  = 4;
  localparam int PROD_WIDTH   = 2 * COORD_WIDTH;
  localparam int CROSS_WIDTH  = PROD_WIDTH + 1;
  localparam int SUM_WIDTH    = COORD_WIDTH + 1;
  localparam int AREA2_WIDTH  = CROSS_WIDTH + 2;
  localparam int AREA_WIDTH   = 2 * COORD_WIDTH + 3;
  localparam int SPLIT_LO     = COORD_WIDTH;
  localparam int SPLIT_HI     = CROSS_WIDTH - SPLIT_LO;
  localparam int PLO_WIDTH    = SUM_WIDTH + SPLIT_LO + 1;
  localparam int PHI_WIDTH    = SUM_WIDTH + SPLIT_HI;
  localparam int EDGE_WIDTH   = SUM_WIDTH + CROSS_WIDTH;
  localparam int MOMENT_WIDTH = EDGE_WIDTH + 2;
  localparam int DEN_WIDTH    = AREA2_WIDTH + 2;
  localparam int CMP_WIDTH    = DEN_WIDTH + COORD_WIDTH;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex0_y;
    logic signed [COORD_WIDTH-1:0] vertex0_z;
    logic signed [COORD_WIDTH-1:0] vertex1_y;
    logic signed [COORD_WIDTH-1:0] vertex1_z;
    logic signed [COORD_WIDTH-1:0] vertex2_y;
    logic signed [COORD_WIDTH-1:0] vertex2_z;
    logic signed [COORD_WIDTH-1:0] vertex3_y;
    logic signed [COORD_WIDTH-1:0] vertex3_z;
  } quad_word_t;

  typedef struct packed {
    logic signed [AREA_WIDTH-1:0]  signed_area;
    logic signed [COORD_WIDTH-1:0] centroid_y;
    logic signed [COORD_WIDTH-1:0] centroid_z;
    logic                          zero_area;
    logic                          centroid_saturated;
  } result_word_t;

  // Word handed from the front end to the divider section.
  typedef struct packed {
    logic signed [AREA_WIDTH-1:0]   area;
    logic signed [AREA2_WIDTH-1:0]  area2;
    logic signed [MOMENT_WIDTH-1:0] moment_y;
    logic signed [MOMENT_WIDTH-1:0] moment_z;
    logic                           zero;
  } moment_word_t;

endpackage
`default_nettype wire

// File: sv/qac_front.sv
// Front end: cross products, doubled area and first moments of one quadrilateral.
`timescale 1ns / 1ps
`default_nettype none
module qac_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  qac_pkg::quad_word_t  item,
  output logic                 push,
  input  logic                 full,
  output qac_pkg::moment_word_t push_word
);
  import qac_pkg::*;

  logic signed [COORD_WIDTH-1:0] y [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] z [NUM_CORNERS];

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic en;

  logic signed [PROD_WIDTH-1:0]  prod_a [NUM_CORNERS];
  logic signed [PROD_WIDTH-1:0]  prod_a_next [NUM_CORNERS];
  logic signed [PROD_WIDTH-1:0]  prod_b [NUM_CORNERS];
  logic signed [PROD_WIDTH-1:0]  prod_b_next [NUM_CORNERS];
  logic signed [SUM_WIDTH-1:0]   sum_y1 [NUM_CORNERS];
  logic signed [SUM_WIDTH-1:0]   sum_y1_next [NUM_CORNERS];
  logic signed [SUM_WIDTH-1:0]   sum_z1 [NUM_CORNERS];
  logic signed [SUM_WIDTH-1:0]   sum_z1_next [NUM_CORNERS];

  logic signed [CROSS_WIDTH-1:0] edge_cross [NUM_CORNERS];
  logic signed [CROSS_WIDTH-1:0] edge_cross_next [NUM_CORNERS];
  logic signed [SUM_WIDTH-1:0]   sum_y2 [NUM_CORNERS];
  logic signed [SUM_WIDTH-1:0]   sum_z2 [NUM_CORNERS];

  logic signed [AREA2_WIDTH-1:0] area2_s3;
  logic signed [AREA2_WIDTH-1:0] area2_s3_next;
  logic signed [PLO_WIDTH-1:0]   lo_y [NUM_CORNERS];
  logic signed [PLO_WIDTH-1:0]   lo_y_next [NUM_CORNERS];
  logic signed [PLO_WIDTH-1:0]   lo_z [NUM_CORNERS];
  logic signed [PLO_WIDTH-1:0]   lo_z_next [NUM_CORNERS];
  logic signed [PHI_WIDTH-1:0]   hi_y [NUM_CORNERS];
  logic signed [PHI_WIDTH-1:0]   hi_y_next [NUM_CORNERS];
  logic signed [PHI_WIDTH-1:0]   hi_z [NUM_CORNERS];
  logic signed [PHI_WIDTH-1:0]   hi_z_next [NUM_CORNERS];

  logic signed [AREA2_WIDTH-1:0] area2_s4;
  logic signed [AREA_WIDTH-1:0]  area_s4;
  logic signed [AREA_WIDTH-1:0]  area_s4_next;
  logic                          zero_s4;
  logic signed [EDGE_WIDTH-1:0]  edge_y [NUM_CORNERS];
  logic signed [EDGE_WIDTH-1:0]  edge_y_next [NUM_CORNERS];
  logic signed [EDGE_WIDTH-1:0]  edge_z [NUM_CORNERS];
  logic signed [EDGE_WIDTH-1:0]  edge_z_next [NUM_CORNERS];

  moment_word_t                  push_word_next;

  assign y[0] = item.vertex0_y;
  assign z[0] = item.vertex0_z;
  assign y[1] = item.vertex1_y;
  assign z[1] = item.vertex1_z;
  assign y[2] = item.vertex2_y;
  assign z[2] = item.vertex2_z;
  assign y[3] = item.vertex3_y;
  assign z[3] = item.vertex3_z;

  // The whole front moves together; it only holds when its last word cannot enter the queue.
  assign en         = !(s5_valid && full);
  assign item_stall = !en;
  assign push       = s5_valid && en;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      prod_a_next[i] = PROD_WIDTH'(y[i]) * PROD_WIDTH'(z[(i + 1) % NUM_CORNERS]);
      prod_b_next[i] = PROD_WIDTH'(y[(i + 1) % NUM_CORNERS]) * PROD_WIDTH'(z[i]);
      sum_y1_next[i] = SUM_WIDTH'(y[i]) + SUM_WIDTH'(y[(i + 1) % NUM_CORNERS]);
      sum_z1_next[i] = SUM_WIDTH'(z[i]) + SUM_WIDTH'(z[(i + 1) % NUM_CORNERS]);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      edge_cross_next[i] = CROSS_WIDTH'(prod_a[i]) - CROSS_WIDTH'(prod_b[i]);
    end
  end

  // Each edge weight times cross product is split into two narrower products.
  always_comb begin
    area2_s3_next = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      area2_s3_next = area2_s3_next + AREA2_WIDTH'(edge_cross[i]);
      lo_y_next[i] = PLO_WIDTH'(sum_y2[i]) *
                     PLO_WIDTH'($signed({1'b0, edge_cross[i][SPLIT_LO-1:0]}));
      lo_z_next[i] = PLO_WIDTH'(sum_z2[i]) *
                     PLO_WIDTH'($signed({1'b0, edge_cross[i][SPLIT_LO-1:0]}));
      hi_y_next[i] = PHI_WIDTH'(sum_y2[i]) *
                     PHI_WIDTH'($signed(edge_cross[i][CROSS_WIDTH-1:SPLIT_LO]));
      hi_z_next[i] = PHI_WIDTH'(sum_z2[i]) *
                     PHI_WIDTH'($signed(edge_cross[i][CROSS_WIDTH-1:SPLIT_LO]));
    end
  end

  always_comb begin
    logic [AREA2_WIDTH-1:0] rounded;
    // Halving rounds toward zero: a negative sum is bumped up by one first.
    rounded = area2_s3 + {{(AREA2_WIDTH-1){1'b0}}, area2_s3[AREA2_WIDTH-1]};
    area_s4_next = AREA_WIDTH'($signed({rounded[AREA2_WIDTH-1], rounded[AREA2_WIDTH-1:1]}));
    for (int i = 0; i < NUM_CORNERS; i++) begin
      edge_y_next[i] = (EDGE_WIDTH'(hi_y[i]) <<< SPLIT_LO) + EDGE_WIDTH'(lo_y[i]);
      edge_z_next[i] = (EDGE_WIDTH'(hi_z[i]) <<< SPLIT_LO) + EDGE_WIDTH'(lo_z[i]);
    end
  end

  always_comb begin
    push_word_next.area     = area_s4;
    push_word_next.area2    = area2_s4;
    push_word_next.zero     = zero_s4;
    push_word_next.moment_y = '0;
    push_word_next.moment_z = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      push_word_next.moment_y = push_word_next.moment_y + MOMENT_WIDTH'(edge_y[i]);
      push_word_next.moment_z = push_word_next.moment_z + MOMENT_WIDTH'(edge_z[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        prod_a[i]     <= prod_a_next[i];
        prod_b[i]     <= prod_b_next[i];
        sum_y1[i]     <= sum_y1_next[i];
        sum_z1[i]     <= sum_z1_next[i];
        edge_cross[i] <= edge_cross_next[i];
        sum_y2[i]     <= sum_y1[i];
        sum_z2[i]     <= sum_z1[i];
        lo_y[i]       <= lo_y_next[i];
        lo_z[i]       <= lo_z_next[i];
        hi_y[i]       <= hi_y_next[i];
        hi_z[i]       <= hi_z_next[i];
        edge_y[i]     <= edge_y_next[i];
        edge_z[i]     <= edge_z_next[i];
      end
      area2_s3  <= area2_s3_next;
      area2_s4  <= area2_s3;
      area_s4   <= area_s4_next;
      zero_s4   <= (area2_s3 == '0);
      push_word <= push_word_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/qac_queue.sv
// Short first-in first-out queue between the front end and the divider section.
`timescale 1ns / 1ps
`default_nettype none
`include "quad_area_centroid_defines.svh"
module qac_queue #(
  parameter int DEPTH = qac_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  qac_pkg::moment_word_t push_word,
  output logic                  full,
  input  logic                  pop,
  output qac_pkg::moment_word_t pop_word,
  output logic                  empty
);
  import qac_pkg::*;

  localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  moment_word_t           slots [DEPTH];
  logic [PTR_WIDTH-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_WIDTH-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_WIDTH-1:0]   count, count_next;

  assign full     = (count == CNT_WIDTH'(DEPTH));
  assign empty    = (count == '0);
  assign pop_word = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  `QAC_ASSERT(a_no_push_when_full, clk, rst, !(push && full), "queue written while full")
  `QAC_ASSERT(a_no_pop_when_empty, clk, rst, !(pop && empty), "queue read while empty")
  `QAC_ASSERT_NEXT(a_count_rises, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue fill count did not rise on a lone write")
  `QAC_ASSERT_NEXT(a_count_falls, clk, rst, pop && !push, count == $past(count) - 1'b1, "queue fill count did not fall on a lone read")

endmodule
`default_nettype wire

// File: sv/qac_back.sv
// Divider section: pipelined restoring division of the moments by three times the doubled area.
`timescale 1ns / 1ps
`default_nettype none
module qac_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  output logic                  pop,
  input  qac_pkg::moment_word_t pop_word,
  output logic                  result_valid,
  input  logic                  result_stall,
  output qac_pkg::result_word_t result
);
  import qac_pkg::*;

  typedef struct packed {
    logic [MOMENT_WIDTH-1:0]       mag_y;
    logic [MOMENT_WIDTH-1:0]       mag_z;
    logic [DEN_WIDTH-1:0]          den;
    logic                          neg_y;
    logic                          neg_z;
    logic signed [AREA_WIDTH-1:0]  area;
    logic                          zero;
  } abs_stage_t;

  typedef struct packed {
    logic [MOMENT_WIDTH-1:0]       rem_y;
    logic [MOMENT_WIDTH-1:0]       rem_z;
    logic [DEN_WIDTH-1:0]          den;
    logic [COORD_WIDTH-1:0]        quo_y;
    logic [COORD_WIDTH-1:0]        quo_z;
    logic                          ovf_y;
    logic                          ovf_z;
    logic                          neg_y;
    logic                          neg_z;
    logic signed [AREA_WIDTH-1:0]  area;
    logic                          zero;
  } div_stage_t;

  logic                   en;
  logic                   abs_valid;
  abs_stage_t             abs_st, abs_st_next;
  logic                   div_valid [COORD_WIDTH+1];
  div_stage_t             div_st [COORD_WIDTH+1];
  div_stage_t             div_st0_next;
  result_word_t           result_next;

  // Saturate a quotient magnitude and apply its sign; the top bit of the return is the flag.
  function automatic logic [COORD_WIDTH:0] finish(input logic [COORD_WIDTH-1:0] quo,
                                                  input logic ovf, input logic neg);
    logic [COORD_WIDTH-1:0] lim;
    logic [COORD_WIDTH-1:0] mag;
    logic                   sat;
    lim = neg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    sat = ovf || (quo > lim);
    mag = sat ? lim : quo;
    return {sat, (neg ? COORD_WIDTH'(-mag) : mag)};
  endfunction

  assign en  = !(result_valid && result_stall);
  assign pop = en && !empty;

  always_comb begin
    logic [AREA2_WIDTH-1:0] mag_a2;
    mag_a2 = pop_word.area2[AREA2_WIDTH-1] ? AREA2_WIDTH'(-pop_word.area2)
                                           : AREA2_WIDTH'(pop_word.area2);
    abs_st_next.mag_y = pop_word.moment_y[MOMENT_WIDTH-1] ? MOMENT_WIDTH'(-pop_word.moment_y)
                                                          : MOMENT_WIDTH'(pop_word.moment_y);
    abs_st_next.mag_z = pop_word.moment_z[MOMENT_WIDTH-1] ? MOMENT_WIDTH'(-pop_word.moment_z)
                                                          : MOMENT_WIDTH'(pop_word.moment_z);
    abs_st_next.den   = (DEN_WIDTH'(mag_a2) << 1) + DEN_WIDTH'(mag_a2);
    abs_st_next.neg_y = pop_word.moment_y[MOMENT_WIDTH-1] ^ pop_word.area2[AREA2_WIDTH-1];
    abs_st_next.neg_z = pop_word.moment_z[MOMENT_WIDTH-1] ^ pop_word.area2[AREA2_WIDTH-1];
    abs_st_next.area  = pop_word.area;
    abs_st_next.zero  = pop_word.zero;
  end

  // Any quotient of 2^COORD_WIDTH or more is out of range whatever its sign.
  always_comb begin
    div_st0_next.rem_y = abs_st.mag_y;
    div_st0_next.rem_z = abs_st.mag_z;
    div_st0_next.den   = abs_st.den;
    div_st0_next.quo_y = '0;
    div_st0_next.quo_z = '0;
    div_st0_next.ovf_y = CMP_WIDTH'(abs_st.mag_y) >= {abs_st.den, {COORD_WIDTH{1'b0}}};
    div_st0_next.ovf_z = CMP_WIDTH'(abs_st.mag_z) >= {abs_st.den, {COORD_WIDTH{1'b0}}};
    div_st0_next.neg_y = abs_st.neg_y;
    div_st0_next.neg_z = abs_st.neg_z;
    div_st0_next.area  = abs_st.area;
    div_st0_next.zero  = abs_st.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid    <= 1'b0;
      div_valid[0] <= 1'b0;
    end else if (en) begin
      abs_valid    <= pop;
      div_valid[0] <= abs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_st    <= abs_st_next;
      div_st[0] <= div_st0_next;
    end
  end

  for (genvar t = 0; t < COORD_WIDTH; t++) begin : g_step
    localparam int K = COORD_WIDTH - 1 - t;
    logic [CMP_WIDTH-1:0] sub_d;
    div_stage_t           step_next;

    assign sub_d = CMP_WIDTH'(div_st[t].den) << K;

    always_comb begin
      step_next = div_st[t];
      if (CMP_WIDTH'(div_st[t].rem_y) >= sub_d) begin
        step_next.rem_y    = MOMENT_WIDTH'(CMP_WIDTH'(div_st[t].rem_y) - sub_d);
        step_next.quo_y[K] = 1'b1;
      end
      if (CMP_WIDTH'(div_st[t].rem_z) >= sub_d) begin
        step_next.rem_z    = MOMENT_WIDTH'(CMP_WIDTH'(div_st[t].rem_z) - sub_d);
        step_next.quo_z[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_valid[t+1] <= 1'b0;
      end else if (en) begin
        div_valid[t+1] <= div_valid[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_st[t+1] <= step_next;
      end
    end
  end

  always_comb begin
    logic [COORD_WIDTH:0] fy;
    logic [COORD_WIDTH:0] fz;
    fy = finish(div_st[COORD_WIDTH].quo_y, div_st[COORD_WIDTH].ovf_y, div_st[COORD_WIDTH].neg_y);
    fz = finish(div_st[COORD_WIDTH].quo_z, div_st[COORD_WIDTH].ovf_z, div_st[COORD_WIDTH].neg_z);
    if (div_st[COORD_WIDTH].zero) begin
      result_next.signed_area        = '0;
      result_next.centroid_y         = '0;
      result_next.centroid_z         = '0;
      result_next.zero_area          = 1'b1;
      result_next.centroid_saturated = 1'b0;
    end else begin
      result_next.signed_area        = div_st[COORD_WIDTH].area;
      result_next.centroid_y         = $signed(fy[COORD_WIDTH-1:0]);
      result_next.centroid_z         = $signed(fz[COORD_WIDTH-1:0]);
      result_next.zero_area          = 1'b0;
      result_next.centroid_saturated = fy[COORD_WIDTH] | fz[COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= div_valid[COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/quad_area_centroid.sv
// Top level of the quadrilateral shoelace area and centroid block.
// A word accepted by the front passes through five front stages, the queue, the magnitude
// and range-check stages, one divider stage per quotient bit and the output register.
// Throughput: one word per cycle unless stalled; the two-lane divider is fully pipelined.
// Reset clears only valid bits, queue pointers and count; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module quad_area_centroid #(
  parameter int QUEUE_DEPTH = qac_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  qac_pkg::quad_word_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output qac_pkg::result_word_t result
);
  import qac_pkg::*;

  // The front forms the doubled area and both first moments exactly; each word then waits
  // in a short queue so a stalled output holds the divider, and the front only if it fills.
  logic         push;
  logic         full;
  logic         pop;
  logic         empty;
  moment_word_t push_word;
  moment_word_t pop_word;

  qac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .full       (full),
    .push_word  (push_word)
  );

  qac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (empty)
  );

  // The back end divides both moments by three times the doubled area, truncating toward
  // zero, saturates to the coordinate range and handles the degenerate zero-area case.
  qac_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop          (pop),
    .pop_word     (pop_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
